// ===== hw/rtl/rlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_pkg
// shared types, constants and helpers of the reflectance line position block
// ----------------------------------------------------------------------------
package rlp_pkg;

  localparam int CHANNELS    = 5;
  localparam int SAMPLE_W    = 10;
  localparam int CH_IDX_W    = 3;
  localparam int POS_W       = 13;
  localparam int LOST_W      = 8;
  localparam int WSUM_W      = 14;
  localparam int TOTAL_W     = 13;
  localparam int DIVIDEND_W  = 24;
  localparam int DIVISOR_W   = 25;
  localparam int QUOT_W      = 13;
  localparam int DIV_CNT_W   = 4;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 64;

  localparam logic [DIV_CNT_W-1:0] CH_QUOT_BITS  = 4'd10;
  localparam logic [DIV_CNT_W-1:0] POS_QUOT_BITS = 4'd13;

  localparam logic [SAMPLE_W-1:0] SCALE_FULL    = 10'd1000;
  localparam logic [SAMPLE_W-1:0] ON_LINE_LIMIT = 10'd800;
  localparam logic [SAMPLE_W-1:0] NOISE_FLOOR   = 10'd50;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 10'd1023;

  localparam logic [POS_W-1:0] POS_SPLIT = 13'd3050;
  localparam logic [POS_W-1:0] POS_LEFT  = 13'd2500;
  localparam logic [POS_W-1:0] POS_RIGHT = 13'd3500;
  localparam logic [POS_W-1:0] POS_RESET = 13'd3000;
  localparam logic [POS_W-1:0] POS_MAX   = 13'd5000;

  localparam logic [LOST_W-1:0] LOST_SAT       = 8'hFF;
  localparam logic [LOST_W-1:0] MAX_LOST_RESET = 8'd3;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_arr_t;

  typedef enum logic [1:0] {
    ACT_READ       = 2'd0,
    ACT_CAL_BEGIN  = 2'd1,
    ACT_CAL_SAMPLE = 2'd2,
    ACT_CAL_FIXED  = 2'd3
  } action_t;

  localparam sample_t FIXED_LOW [CHANNELS] = '{10'd117, 10'd129, 10'd124, 10'd127, 10'd101};
  localparam sample_t FIXED_HIGH [CHANNELS] = '{10'd841, 10'd899, 10'd925, 10'd945, 10'd823};

  // divisor is pre-aligned to the top quotient bit by the requester
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic [DIV_CNT_W-1:0]  nbits;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  // x * 1000 as 1024x - 16x - 8x
  function automatic logic [DIVIDEND_W-1:0] times_1000(input logic [WSUM_W-1:0] x);
    logic [DIVIDEND_W-1:0] xe;
    xe = DIVIDEND_W'(x);
    return (xe << 10) - (xe << 4) - (xe << 3);
  endfunction

endpackage

// ===== hw/rtl/rlp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rlp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rlp_pkg::div_req_t req,
  output rlp_pkg::div_rsp_t rsp
);
  import rlp_pkg::*;

  logic [DIVIDEND_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsh_r, dsh_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [QUOT_W-1:0]     quo_r, quo_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  fits;

  always_comb begin
    fits     = DIVISOR_W'(rem_r) >= dsh_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend;
      dsh_nxt  = req.divisor;
      cnt_nxt  = req.nbits;
      quo_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // trial subtract of the aligned divisor
      if (fits) begin
        rem_nxt = rem_r - DIVIDEND_W'(dsh_r);
      end
      quo_nxt = {quo_r[QUOT_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== hw/rtl/rlp_cal.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_cal
// per-channel low and high calibration levels
// ----------------------------------------------------------------------------
module rlp_cal (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd_en,
  input  rlp_pkg::action_t              action,
  input  rlp_pkg::sample_arr_t          raw,
  input  logic [rlp_pkg::CH_IDX_W-1:0]  rd_idx,
  output rlp_pkg::sample_t              rd_low,
  output rlp_pkg::sample_t              rd_high
);
  import rlp_pkg::*;

  sample_t low_r  [CHANNELS];
  sample_t high_r [CHANNELS];
  sample_t low_nxt  [CHANNELS];
  sample_t high_nxt [CHANNELS];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      low_nxt[i]  = low_r[i];
      high_nxt[i] = high_r[i];
    end
    if (upd_en) begin
      unique case (action)
        ACT_CAL_BEGIN: begin
          for (int i = 0; i < CHANNELS; i++) begin
            low_nxt[i]  = SAMPLE_MAX;
            high_nxt[i] = '0;
          end
        end
        ACT_CAL_SAMPLE: begin
          // zero samples are dropouts and never move a level
          for (int i = 0; i < CHANNELS; i++) begin
            if (raw[i] != '0 && raw[i] > high_r[i]) begin
              high_nxt[i] = raw[i];
            end
            if (raw[i] != '0 && raw[i] < low_r[i]) begin
              low_nxt[i] = raw[i];
            end
          end
        end
        ACT_CAL_FIXED: begin
          for (int i = 0; i < CHANNELS; i++) begin
            low_nxt[i]  = FIXED_LOW[i];
            high_nxt[i] = FIXED_HIGH[i];
          end
        end
        ACT_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        low_r[i]  <= FIXED_LOW[i];
        high_r[i] <= FIXED_HIGH[i];
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        low_r[i]  <= low_nxt[i];
        high_r[i] <= high_nxt[i];
      end
    end
  end

  assign rd_low  = low_r[rd_idx];
  assign rd_high = high_r[rd_idx];

endmodule

// ===== hw/rtl/reflectance_line_position.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflectance_line_position
// calibrated five-channel reflectance scaling and weighted line position
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             contents
//  in_      in   tvalid/tready         tdata: raw_ch0..raw_ch4, tuser: action, invert
//  out_     out  tvalid/tready         tdata: line_position, scaled_ch0..scaled_ch4
//  cfg_     in   we                    wdata: max_lost_reads
//
// calibration words are taken in idle; the block is ready again on the next clock
// a read word runs S_CH then S_ACC per channel, with S_CH_DIV between when the channel
// needs the divider, then S_POS, with S_POS_DIV for the averaging divide, and S_OUT;
// no new word is taken until it is back in idle; the one serial divider, a quotient bit per clock, serves both divides
// a finished word waits in the output register while the next word is taken; that
// result stalls until the register drains; synchronous reset loads the fixed tables
//
module reflectance_line_position (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // raw_ch0, raw_ch1, raw_ch2, raw_ch3, raw_ch4, zero fill
  input  logic [rlp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action, invert
  input  logic [rlp_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // line_position, scaled_ch0, scaled_ch1, scaled_ch2, scaled_ch3, scaled_ch4, zero fill
  output logic [rlp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [rlp_pkg::LOST_W-1:0]         cfg_wdata
);
  import rlp_pkg::*;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CH      = 7'b0000010,
    S_CH_DIV  = 7'b0000100,
    S_ACC     = 7'b0001000,
    S_POS     = 7'b0010000,
    S_POS_DIV = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CH_IDX_W-1:0]    ch_r, ch_nxt;
  sample_arr_t            raw_r, raw_nxt;
  logic                   white_r, white_nxt;
  sample_arr_t            scaled_r, scaled_nxt;
  logic [WSUM_W-1:0]      wsum_r, wsum_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;
  logic                   on_line_r, on_line_nxt;
  logic [LOST_W-1:0]      lost_r, lost_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [LOST_W-1:0]      max_lost_r;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                   in_accept;
  action_t                in_action;
  sample_t                cal_low, cal_high;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // per-channel scaling terms
  sample_t                raw_cur, diff, span;
  logic                   span_ok, above_low, at_top;

  // accumulate terms
  sample_t                sc_cur, val;
  logic [WSUM_W-1:0]      weight, weighted;

  // lost-line terms
  logic [LOST_W-1:0]      lost_inc;
  logic                   snap;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign in_action  = action_t'(in_tuser[1:0]);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  rlp_cal u_cal (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd_en  (in_accept && (in_action != ACT_READ)),
    .action  (in_action),
    .raw     (in_tdata[CHANNELS*SAMPLE_W-1:0]),
    .rd_idx  (ch_r),
    .rd_low  (cal_low),
    .rd_high (cal_high)
  );

  rlp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    raw_cur   = raw_r[ch_r];
    span_ok   = cal_high > cal_low;
    above_low = raw_cur > cal_low;
    // at or above the high level the quotient reaches 1000 and clamps there
    at_top    = raw_cur >= cal_high;
    diff      = raw_cur - cal_low;
    span      = cal_high - cal_low;

    sc_cur    = scaled_r[ch_r];
    val       = white_r ? (SCALE_FULL - sc_cur) : sc_cur;
    weight    = WSUM_W'(ch_r) + WSUM_W'(1);
    weighted  = WSUM_W'(val) * weight;

    if (on_line_r) begin
      lost_inc = '0;
    end else if (lost_r != LOST_SAT) begin
      lost_inc = lost_r + 1'b1;
    end else begin
      lost_inc = lost_r;
    end
    snap = lost_inc >= max_lost_r;
  end

  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    raw_nxt        = raw_r;
    white_nxt      = white_r;
    scaled_nxt     = scaled_r;
    wsum_nxt       = wsum_r;
    total_nxt      = total_r;
    on_line_nxt    = on_line_r;
    lost_nxt       = lost_r;
    pos_nxt        = pos_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    div_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept && in_action == ACT_READ) begin
          raw_nxt     = in_tdata[CHANNELS*SAMPLE_W-1:0];
          white_nxt   = in_tuser[2];
          ch_nxt      = '0;
          wsum_nxt    = '0;
          total_nxt   = '0;
          on_line_nxt = 1'b0;
          state_nxt   = S_CH;
        end
      end
      S_CH: begin
        if (!span_ok || !above_low) begin
          scaled_nxt[ch_r] = '0;
          state_nxt        = S_ACC;
        end else if (at_top) begin
          scaled_nxt[ch_r] = SCALE_FULL;
          state_nxt        = S_ACC;
        end else begin
          // below the high level the quotient stays under 1000
          div_req.start    = 1'b1;
          div_req.dividend = times_1000(WSUM_W'(diff));
          div_req.divisor  = DIVISOR_W'(span) << (CH_QUOT_BITS - 1'b1);
          div_req.nbits    = CH_QUOT_BITS;
          state_nxt        = S_CH_DIV;
        end
      end
      S_CH_DIV: begin
        if (div_rsp.done) begin
          scaled_nxt[ch_r] = div_rsp.quotient[SAMPLE_W-1:0];
          state_nxt        = S_ACC;
        end
      end
      S_ACC: begin
        if (val < ON_LINE_LIMIT) begin
          on_line_nxt = 1'b1;
        end
        // noise gate on both sums
        if (val > NOISE_FLOOR) begin
          wsum_nxt  = wsum_r + weighted;
          total_nxt = total_r + TOTAL_W'(val);
        end
        if (ch_r == CH_IDX_W'(CHANNELS - 1)) begin
          state_nxt = S_POS;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_CH;
        end
      end
      S_POS: begin
        lost_nxt = snap ? max_lost_r : lost_inc;
        if (snap) begin
          pos_nxt = (pos_r < POS_SPLIT) ? POS_LEFT : POS_RIGHT;
        end
        if (on_line_r && total_r != '0) begin
          div_req.start    = 1'b1;
          div_req.dividend = times_1000(wsum_r);
          div_req.divisor  = DIVISOR_W'(total_r) << (POS_QUOT_BITS - 1'b1);
          div_req.nbits    = POS_QUOT_BITS;
          state_nxt        = S_POS_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_POS_DIV: begin
        if (div_rsp.done) begin
          pos_nxt   = div_rsp.quotient[POS_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // wait for the output register to drain
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = OUT_TDATA_W'({scaled_r, pos_r});
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lost_r       <= '0;
      pos_r        <= POS_RESET;
      max_lost_r   <= MAX_LOST_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      lost_r       <= lost_nxt;
      pos_r        <= pos_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        max_lost_r <= cfg_wdata;
      end
    end
    ch_r        <= ch_nxt;
    raw_r       <= raw_nxt;
    white_r     <= white_nxt;
    scaled_r    <= scaled_nxt;
    wsum_r      <= wsum_nxt;
    total_r     <= total_nxt;
    on_line_r   <= on_line_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

// ===== hw/rtl/rlp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_checker
// port-level checks of the reflectance line position block
// ----------------------------------------------------------------------------
module rlp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [rlp_pkg::IN_TUSER_W-1:0]     in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [rlp_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import rlp_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result word changed while stalled");

  // a read word occupies the sequencer
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[1:0] == ACT_READ) |=> !in_tready)
    else $error("ready after accepting a read word");

  // calibration words leave the input ready on the next clock
  a_cal_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[1:0] != ACT_READ) |=> in_tready)
    else $error("calibration word stalled the input");

  // position and scaled values stay in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:0] <= POS_MAX && out_tdata[22:13] <= SCALE_FULL &&
                    out_tdata[32:23] <= SCALE_FULL && out_tdata[42:33] <= SCALE_FULL &&
                    out_tdata[52:43] <= SCALE_FULL && out_tdata[62:53] <= SCALE_FULL))
    else $error("result field out of range");

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("output valid or input stalled after reset");

endmodule

bind reflectance_line_position rlp_checker u_rlp_checker (.*);
